FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every rising edge outside reset
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never holds outside reset
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

FILE: hw/rtl/strra_pkg.sv
// ----------------------------------------------------------------------------
// Session table arbiter package
// Sizes, sequencer states, store control bundle and slot helpers.
// ----------------------------------------------------------------------------
package strra_pkg;

  localparam int SLOTS        = 8;
  localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MASK_W       = 8;
  localparam int MASK_IDX_W   = $clog2(MASK_W);
  localparam int ADDR_W       = 32;
  localparam int PORT_W       = 16;
  localparam int ENTRY_W      = ADDR_W + PORT_W;
  localparam int GRANT_SLOT_W = 3;
  localparam int COUNT_W      = 4;
  localparam int COUNT_MAX    = 15;
  localparam int CNT_W        = $clog2(SLOTS + 1);

  typedef logic [SLOT_W-1:0] slot_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_PLACE,
    ST_PRUNE,
    ST_SCAN,
    ST_FETCH,
    ST_DONE
  } state_t;

  // Control of the address/port store
  typedef struct packed {
    logic      wr_en;
    slot_idx_t wr_addr;
    slot_idx_t rd_addr;
  } store_ctl_t;

  // Slots past the mask width have no bit and read as closed
  function automatic logic mask_bit(input logic [MASK_W-1:0] mask, input slot_idx_t idx);
    if (int'(idx) >= MASK_W) begin
      return 1'b0;
    end
    return mask[MASK_IDX_W'(idx)];
  endfunction

  // Step to the following slot with wrap
  function automatic slot_idx_t wrap_next(input slot_idx_t idx);
    if (idx == SLOT_W'(SLOTS - 1)) begin
      return '0;
    end
    return idx + 1'b1;
  endfunction

endpackage

FILE: hw/rtl/strra_slot_store.sv
// ----------------------------------------------------------------------------
// Slot store
// One write port and one registered read port holding each slot's client.
// ----------------------------------------------------------------------------
module strra_slot_store (
  input  logic                          clk,
  input  strra_pkg::store_ctl_t         ctl,
  input  logic [strra_pkg::ENTRY_W-1:0] wr_data,
  output logic [strra_pkg::ENTRY_W-1:0] rd_data
);

  logic [strra_pkg::ENTRY_W-1:0] mem [strra_pkg::SLOTS];
  logic [strra_pkg::ENTRY_W-1:0] rd_data_r;

  // Write the entry
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= wr_data;
    end
  end

  // Registered read of the addressed entry
  always_ff @(posedge clk) begin
    rd_data_r <= mem[ctl.rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/session_table_round_robin_arbiter.sv
// ----------------------------------------------------------------------------
// Session table round-robin arbiter
// Tracks up to SLOTS clients and grants one connected client a bus turn.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one request is one scheduling round,
//   carrying an optional new client plus connection, pending and bus masks.
//   Result channel (out_valid / out_stall): one result per round with the
//   grant, the stored client of the granted slot, active count, full flag.
//   Config channel (cfg_valid / cfg_ready): writes converter_enable; always
//   ready, write only while no round is in flight.
// Sequence:
//   A round walks the table with one compare unit over the store's single
//   read port: a lookup and placement walk when a new client comes along,
//   a pruning step, a round-robin scan over all slots and a fetch of the
//   winner's entry, then the result lands in the output register. With the
//   converter disabled a round goes straight to the result.
//   One round is in flight at a time; in_stall is high while it runs, and the
//   next round is taken when the sequencer is back in idle after the result.
// Reset: all slots free, pointer at slot zero, converter disabled.
// Stall: a result waits in the output register; the next round may be
//   accepted meanwhile and waits at its end until the register frees up.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module session_table_round_robin_arbiter (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_data,
  // request channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_new_valid,
  input  logic [strra_pkg::ADDR_W-1:0]       in_new_address,
  input  logic [strra_pkg::PORT_W-1:0]       in_new_port,
  input  logic [strra_pkg::MASK_W-1:0]       in_connected_mask,
  input  logic [strra_pkg::MASK_W-1:0]       in_pending_mask,
  input  logic                               in_bus_busy,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_grant_valid,
  output logic [strra_pkg::GRANT_SLOT_W-1:0] out_grant_slot,
  output logic [strra_pkg::ADDR_W-1:0]       out_grant_address,
  output logic [strra_pkg::PORT_W-1:0]       out_grant_port,
  output logic [strra_pkg::COUNT_W-1:0]      out_active_count,
  output logic                               out_table_full
);

  localparam int SUM_W = strra_pkg::SLOT_W + 1;
  localparam strra_pkg::slot_idx_t LAST_SLOT = strra_pkg::SLOT_W'(strra_pkg::SLOTS - 1);

  strra_pkg::state_t state_r, state_nxt;

  logic                          enable_r;
  logic [strra_pkg::SLOTS-1:0]   slot_used_r, used_nxt;
  strra_pkg::slot_idx_t          ptr_r, ptr_nxt;

  // latched request
  logic [strra_pkg::ADDR_W-1:0]  addr_r;
  logic [strra_pkg::PORT_W-1:0]  port_r;
  logic [strra_pkg::MASK_W-1:0]  conn_r;
  logic [strra_pkg::MASK_W-1:0]  pend_r;
  logic                          busy_r;

  // walk trackers
  strra_pkg::slot_idx_t          idx_r, idx_nxt;
  logic                          cmp_live_r, cmp_live_nxt;
  strra_pkg::slot_idx_t          cmp_idx_r, cmp_idx_nxt;
  logic                          found_r, found_nxt;
  logic                          free_found_r, free_found_nxt;
  strra_pkg::slot_idx_t          free_idx_r, free_idx_nxt;
  logic                          full_r, full_nxt;
  strra_pkg::slot_idx_t          step_r, step_nxt;
  logic [strra_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic                          win_found_r, win_found_nxt;
  strra_pkg::slot_idx_t          win_idx_r, win_idx_nxt;

  // output register
  logic                               out_valid_r, out_valid_nxt;
  logic                               grant_valid_r, grant_valid_nxt;
  logic [strra_pkg::GRANT_SLOT_W-1:0] grant_slot_r, grant_slot_nxt;
  logic [strra_pkg::ADDR_W-1:0]       grant_address_r, grant_address_nxt;
  logic [strra_pkg::PORT_W-1:0]       grant_port_r, grant_port_nxt;
  logic [strra_pkg::COUNT_W-1:0]      active_count_r, active_count_nxt;
  logic                               table_full_r, table_full_nxt;

  logic                          in_accept;
  strra_pkg::store_ctl_t         store_ctl;
  logic [strra_pkg::ENTRY_W-1:0] rd_data;
  logic [strra_pkg::SLOTS-1:0]   conn_slots;
  logic [SUM_W-1:0]              scan_sum;
  strra_pkg::slot_idx_t          scan_idx;
  logic                          cmp_used;
  logic                          hit;
  logic                          free_hit;
  logic [strra_pkg::COUNT_W-1:0] count_sat;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != strra_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // Address/port store
  strra_slot_store u_store (
    .clk     (clk),
    .ctl     (store_ctl),
    .wr_data ({addr_r, port_r}),
    .rd_data (rd_data)
  );

  // Expand the connection mask to one bit per slot
  always_comb begin
    for (int i = 0; i < strra_pkg::SLOTS; i++) begin
      conn_slots[i] = strra_pkg::mask_bit(conn_r, strra_pkg::SLOT_W'(i));
    end
  end

  // Round-robin scan index: pointer plus step, wrapped once
  assign scan_sum = {1'b0, ptr_r} + {1'b0, step_r};
  assign scan_idx = (scan_sum >= SUM_W'(strra_pkg::SLOTS))
                    ? strra_pkg::SLOT_W'(scan_sum - SUM_W'(strra_pkg::SLOTS))
                    : strra_pkg::SLOT_W'(scan_sum);

  // Shared compare on the entry read out last cycle
  assign cmp_used = slot_used_r[cmp_idx_r];
  assign hit      = cmp_live_r && cmp_used && (rd_data == {addr_r, port_r});
  assign free_hit = cmp_live_r && !cmp_used;

  assign count_sat = (int'(count_r) > strra_pkg::COUNT_MAX)
                     ? strra_pkg::COUNT_W'(strra_pkg::COUNT_MAX)
                     : strra_pkg::COUNT_W'(count_r);

  // Sequencer: next state, walk trackers and store control
  always_comb begin
    state_nxt         = state_r;
    used_nxt          = slot_used_r;
    ptr_nxt           = ptr_r;
    idx_nxt           = idx_r;
    cmp_live_nxt      = 1'b0;
    cmp_idx_nxt       = cmp_idx_r;
    found_nxt         = found_r;
    free_found_nxt    = free_found_r;
    free_idx_nxt      = free_idx_r;
    full_nxt          = full_r;
    step_nxt          = step_r;
    count_nxt         = count_r;
    win_found_nxt     = win_found_r;
    win_idx_nxt       = win_idx_r;
    store_ctl         = '0;
    store_ctl.rd_addr = win_idx_r;
    out_valid_nxt     = out_valid_r && out_stall;
    grant_valid_nxt   = grant_valid_r;
    grant_slot_nxt    = grant_slot_r;
    grant_address_nxt = grant_address_r;
    grant_port_nxt    = grant_port_r;
    active_count_nxt  = active_count_r;
    table_full_nxt    = table_full_r;

    case (state_r)
      strra_pkg::ST_IDLE: begin
        if (in_accept) begin
          idx_nxt        = '0;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          full_nxt       = 1'b0;
          count_nxt      = '0;
          win_found_nxt  = 1'b0;
          if (!enable_r) begin
            state_nxt = strra_pkg::ST_DONE;
          end else if (in_new_valid) begin
            state_nxt = strra_pkg::ST_LOOKUP;
          end else begin
            state_nxt = strra_pkg::ST_PRUNE;
          end
        end
      end

      // Issue one read per cycle, compare the previous one
      strra_pkg::ST_LOOKUP: begin
        store_ctl.rd_addr = idx_r;
        cmp_live_nxt      = 1'b1;
        cmp_idx_nxt       = idx_r;
        if (hit) begin
          found_nxt = 1'b1;
        end
        if (free_hit && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = cmp_idx_r;
        end
        if (idx_r == LAST_SLOT) begin
          state_nxt = strra_pkg::ST_PLACE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      // Finish the last compare, then place or drop the client
      strra_pkg::ST_PLACE: begin
        if (!(found_r || hit)) begin
          if (free_found_r || free_hit) begin
            store_ctl.wr_en   = 1'b1;
            store_ctl.wr_addr = free_found_r ? free_idx_r : cmp_idx_r;
            used_nxt[store_ctl.wr_addr] = 1'b1;
          end else begin
            full_nxt = 1'b1;
          end
        end
        state_nxt = strra_pkg::ST_PRUNE;
      end

      // Drop slots whose connection closed
      strra_pkg::ST_PRUNE: begin
        used_nxt      = slot_used_r & conn_slots;
        step_nxt      = '0;
        count_nxt     = '0;
        win_found_nxt = 1'b0;
        state_nxt     = strra_pkg::ST_SCAN;
      end

      // Count live slots and pick the first eligible one from the pointer
      strra_pkg::ST_SCAN: begin
        if (slot_used_r[scan_idx]) begin
          count_nxt = count_r + 1'b1;
        end
        if (!busy_r && !win_found_r && slot_used_r[scan_idx] && conn_slots[scan_idx]
            && strra_pkg::mask_bit(pend_r, scan_idx)) begin
          win_found_nxt = 1'b1;
          win_idx_nxt   = scan_idx;
        end
        if (step_r == LAST_SLOT) begin
          state_nxt = strra_pkg::ST_FETCH;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end

      // Read the winner's entry and advance the pointer past it
      strra_pkg::ST_FETCH: begin
        if (win_found_r) begin
          ptr_nxt = strra_pkg::wrap_next(win_idx_r);
        end
        state_nxt = strra_pkg::ST_DONE;
      end

      // Hand the result over once the output register is free
      strra_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt     = 1'b1;
          grant_valid_nxt   = win_found_r;
          grant_slot_nxt    = win_found_r ? strra_pkg::GRANT_SLOT_W'(win_idx_r) : '0;
          grant_address_nxt = win_found_r ? rd_data[strra_pkg::ENTRY_W-1 -: strra_pkg::ADDR_W]
                                          : '0;
          grant_port_nxt    = win_found_r ? rd_data[strra_pkg::PORT_W-1:0] : '0;
          active_count_nxt  = count_sat;
          table_full_nxt    = full_r;
          state_nxt         = strra_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = strra_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= strra_pkg::ST_IDLE;
      enable_r    <= 1'b0;
      slot_used_r <= '0;
      ptr_r       <= '0;
      cmp_live_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_used_r <= used_nxt;
      ptr_r       <= ptr_nxt;
      cmp_live_r  <= cmp_live_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        enable_r <= cfg_data;
      end
    end
  end

  // Request latch, walk trackers and result payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      addr_r <= in_new_address;
      port_r <= in_new_port;
      conn_r <= in_connected_mask;
      pend_r <= in_pending_mask;
      busy_r <= in_bus_busy;
    end
    idx_r           <= idx_nxt;
    cmp_idx_r       <= cmp_idx_nxt;
    found_r         <= found_nxt;
    free_found_r    <= free_found_nxt;
    free_idx_r      <= free_idx_nxt;
    full_r          <= full_nxt;
    step_r          <= step_nxt;
    count_r         <= count_nxt;
    win_found_r     <= win_found_nxt;
    win_idx_r       <= win_idx_nxt;
    grant_valid_r   <= grant_valid_nxt;
    grant_slot_r    <= grant_slot_nxt;
    grant_address_r <= grant_address_nxt;
    grant_port_r    <= grant_port_nxt;
    active_count_r  <= active_count_nxt;
    table_full_r    <= table_full_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_grant_valid   = grant_valid_r;
  assign out_grant_slot    = grant_slot_r;
  assign out_grant_address = grant_address_r;
  assign out_grant_port    = grant_port_r;
  assign out_active_count  = active_count_r;
  assign out_table_full    = table_full_r;

  // Placement only ever fills a free slot
  `ASSERT_NEVER(a_place_free_slot,
    store_ctl.wr_en && slot_used_r[store_ctl.wr_addr],
    "placed into a used slot")
  // After pruning no used slot is disconnected
  `ASSERT_PROP(a_scan_pruned,
    (state_r == strra_pkg::ST_SCAN) |-> ((slot_used_r & ~conn_slots) == '0),
    "disconnected slot still used during scan")
  // Pointer moves only on a grant
  `ASSERT_PROP(a_ptr_on_grant,
    !(state_r == strra_pkg::ST_FETCH && win_found_r) |=> $stable(ptr_r),
    "pointer moved without a grant")
  // A result without a grant carries no client
  `ASSERT_PROP(a_no_grant_clear,
    (out_valid && !out_grant_valid) |-> (out_grant_slot == '0
      && out_grant_address == '0 && out_grant_port == '0),
    "grant fields set without a grant")

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// Session table arbiter testbench
// Runs directed and random scheduling rounds through the arbiter and checks
// each result against a cycle-free model of the client table, its pruning
// and the round-robin grant, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES = 10;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int POOL_SIZE    = 12;

  typedef struct {
    logic                         new_valid;
    logic [strra_pkg::ADDR_W-1:0] new_address;
    logic [strra_pkg::PORT_W-1:0] new_port;
    logic [strra_pkg::MASK_W-1:0] connected_mask;
    logic [strra_pkg::MASK_W-1:0] pending_mask;
    logic                         bus_busy;
  } round_t;

  typedef struct {
    logic                               grant_valid;
    logic [strra_pkg::GRANT_SLOT_W-1:0] grant_slot;
    logic [strra_pkg::ADDR_W-1:0]       grant_address;
    logic [strra_pkg::PORT_W-1:0]       grant_port;
    logic [strra_pkg::COUNT_W-1:0]      active_count;
    logic                               table_full;
  } grant_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic                               cfg_data = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic                               in_new_valid = 1'b0;
  logic [strra_pkg::ADDR_W-1:0]       in_new_address = '0;
  logic [strra_pkg::PORT_W-1:0]       in_new_port = '0;
  logic [strra_pkg::MASK_W-1:0]       in_connected_mask = '0;
  logic [strra_pkg::MASK_W-1:0]       in_pending_mask = '0;
  logic                               in_bus_busy = 1'b0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic                               out_grant_valid;
  logic [strra_pkg::GRANT_SLOT_W-1:0] out_grant_slot;
  logic [strra_pkg::ADDR_W-1:0]       out_grant_address;
  logic [strra_pkg::PORT_W-1:0]       out_grant_port;
  logic [strra_pkg::COUNT_W-1:0]      out_active_count;
  logic                               out_table_full;

  // Model state of the client table
  bit                           conv_enable;
  bit                           tbl_used [strra_pkg::SLOTS];
  logic [strra_pkg::ADDR_W-1:0] tbl_addr [strra_pkg::SLOTS];
  logic [strra_pkg::PORT_W-1:0] tbl_port [strra_pkg::SLOTS];
  int                           rr_ptr;

  grant_t                       expected_grants [$];
  logic [strra_pkg::ADDR_W-1:0] pool_addr [POOL_SIZE];
  logic [strra_pkg::PORT_W-1:0] pool_port [POOL_SIZE];
  bit                           idle_on = 1'b1;
  int                           hold_cycles;
  int                           errors;
  int                           cycle_count;

  session_table_round_robin_arbiter dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_new_valid      (in_new_valid),
    .in_new_address    (in_new_address),
    .in_new_port       (in_new_port),
    .in_connected_mask (in_connected_mask),
    .in_pending_mask   (in_pending_mask),
    .in_bus_busy       (in_bus_busy),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_grant_valid   (out_grant_valid),
    .out_grant_slot    (out_grant_slot),
    .out_grant_address (out_grant_address),
    .out_grant_port    (out_grant_port),
    .out_active_count  (out_active_count),
    .out_table_full    (out_table_full)
  );

  always #10 clk = ~clk;

  // Track new client, prune closed slots, then grant round-robin
  function automatic grant_t schedule_round(round_t r);
    grant_t g;
    bit     found;
    bit     placed;
    bit     granted;
    int     count;
    int     s;
    g = '{default: '0};
    found = 1'b0;
    placed = 1'b0;
    granted = 1'b0;
    count = 0;
    if (conv_enable) begin
      if (r.new_valid) begin
        for (int i = 0; i < strra_pkg::SLOTS; i++) begin
          if (tbl_used[i] && tbl_addr[i] == r.new_address
              && tbl_port[i] == r.new_port) begin
            found = 1'b1;
          end
        end
        if (!found) begin
          for (int i = 0; i < strra_pkg::SLOTS; i++) begin
            if (!placed && !tbl_used[i]) begin
              tbl_used[i] = 1'b1;
              tbl_addr[i] = r.new_address;
              tbl_port[i] = r.new_port;
              placed = 1'b1;
            end
          end
          g.table_full = !placed;
        end
      end
      for (int i = 0; i < strra_pkg::SLOTS; i++) begin
        if (tbl_used[i] && !(i < strra_pkg::MASK_W && r.connected_mask[i])) begin
          tbl_used[i] = 1'b0;
        end
        if (tbl_used[i]) begin
          count++;
        end
      end
      if (!r.bus_busy) begin
        for (int k = 0; k < strra_pkg::SLOTS; k++) begin
          s = (rr_ptr + k) % strra_pkg::SLOTS;
          if (!granted && tbl_used[s] && s < strra_pkg::MASK_W && r.connected_mask[s]
              && r.pending_mask[s]) begin
            granted = 1'b1;
            g.grant_valid = 1'b1;
            g.grant_slot = strra_pkg::GRANT_SLOT_W'(s);
            g.grant_address = tbl_addr[s];
            g.grant_port = tbl_port[s];
            rr_ptr = (s + 1) % strra_pkg::SLOTS;
          end
        end
      end
      g.active_count = (count > strra_pkg::COUNT_MAX)
                       ? strra_pkg::COUNT_W'(strra_pkg::COUNT_MAX)
                       : strra_pkg::COUNT_W'(count);
    end
    return g;
  endfunction

  function automatic round_t make_round(bit nv, logic [strra_pkg::ADDR_W-1:0] addr,
                                        logic [strra_pkg::PORT_W-1:0] port,
                                        logic [strra_pkg::MASK_W-1:0] conn,
                                        logic [strra_pkg::MASK_W-1:0] pend, bit busy);
    round_t r;
    r.new_valid = nv;
    r.new_address = addr;
    r.new_port = port;
    r.connected_mask = conn;
    r.pending_mask = pend;
    r.bus_busy = busy;
    return r;
  endfunction

  // Known clients half the time, mostly open connections, so the table fills and rotates
  function automatic round_t random_round();
    round_t r;
    int     k;
    r.new_valid = ($urandom_range(0, 99) < 65);
    if ($urandom_range(0, 1) == 0) begin
      k = $urandom_range(0, POOL_SIZE - 1);
      r.new_address = pool_addr[k];
      r.new_port = pool_port[k];
    end else begin
      r.new_address = $urandom;
      r.new_port = strra_pkg::PORT_W'($urandom_range(0, 65535));
    end
    if ($urandom_range(0, 99) < 85) begin
      r.connected_mask = '1;
      if ($urandom_range(0, 3) == 0) begin
        r.connected_mask[$urandom_range(0, strra_pkg::MASK_W - 1)] = 1'b0;
      end
    end else begin
      r.connected_mask = strra_pkg::MASK_W'($urandom);
    end
    r.pending_mask = strra_pkg::MASK_W'($urandom);
    r.bus_busy = ($urandom_range(0, 4) == 0);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    end
  endtask

  // Offer one request and hold it until accepted; predict at the accepting edge
  task automatic send_round(round_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_new_valid <= r.new_valid;
    in_new_address <= r.new_address;
    in_new_port <= r.new_port;
    in_connected_mask <= r.connected_mask;
    in_pending_mask <= r.pending_mask;
    in_bus_busy <= r.bus_busy;
    do @(posedge clk); while (!(in_valid && !in_stall));
    expected_grants.push_back(schedule_round(r));
  endtask

  // Drop valid and wait until every outstanding result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_enable(bit value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    conv_enable = value;
    cfg_valid <= 1'b0;
  endtask

  // Disabled rounds leave the table alone and return all-zero results
  task automatic test_disabled_rounds();
    write_enable(1'b0);
    send_round(make_round(1'b1, pool_addr[0], pool_port[0], '1, '1, 1'b0));
    send_round(make_round(1'b1, '1, '1, '1, '1, 1'b1));
    send_round(make_round(1'b0, '0, '0, '0, '1, 1'b0));
    wait_drained();
  endtask

  // Fill all slots, skip a known client, then overflow the table
  task automatic test_table_fill();
    write_enable(1'b1);
    send_round(make_round(1'b1, '0, '0, '1, '0, 1'b0));
    send_round(make_round(1'b1, '1, '1, '1, '0, 1'b0));
    for (int i = 0; i < strra_pkg::SLOTS - 2; i++) begin
      send_round(make_round(1'b1, pool_addr[i], pool_port[i], '1, '0, 1'b0));
    end
    send_round(make_round(1'b1, '1, '1, '1, '0, 1'b0));
    send_round(make_round(1'b1, pool_addr[strra_pkg::SLOTS], pool_port[strra_pkg::SLOTS],
                          '1, '0, 1'b0));
  endtask

  // Rotate grants, hold on a busy bus, wrap the pointer both ways
  task automatic test_grant_rotation();
    send_round(make_round(1'b0, '0, '0, '1, '1, 1'b0));
    send_round(make_round(1'b0, '0, '0, '1, '1, 1'b0));
    send_round(make_round(1'b0, '0, '0, '1, '1, 1'b1));
    send_round(make_round(1'b0, '0, '0, '1, 8'h02, 1'b0));
    send_round(make_round(1'b0, '0, '0, '1, 8'h80, 1'b0));
    send_round(make_round(1'b0, '0, '0, '1, 8'h81, 1'b0));
  endtask

  // Full table plus pruning in one round, refill a freed slot, close everything
  task automatic test_pruning();
    send_round(make_round(1'b1, pool_addr[9], pool_port[9], 8'h0F, '1, 1'b0));
    send_round(make_round(1'b1, pool_addr[10], pool_port[10], 8'h1F, 8'h10, 1'b0));
    send_round(make_round(1'b0, '1, '1, '0, '1, 1'b0));
    send_round(make_round(1'b1, pool_addr[11], pool_port[11], '1, '1, 1'b1));
    wait_drained();
  endtask

  // Hold the result channel off long enough for the input to back up
  task automatic test_backpressure();
    hold_cycles = 300;
    repeat (8) send_round(random_round());
    wait_drained();
  endtask

  task automatic test_random_rounds(bit enable, int rounds);
    write_enable(enable);
    repeat (rounds) send_round(random_round());
  endtask

  // Final stretch with no idling on either side
  task automatic test_quiet_finish();
    wait_drained();
    idle_on = 1'b0;
    repeat (80) send_round(random_round());
  endtask

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_addr[i] = $urandom;
      pool_port[i] = strra_pkg::PORT_W'($urandom_range(0, 65535));
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_disabled_rounds();
    test_table_fill();
    test_grant_rotation();
    test_pruning();
    test_backpressure();
    test_random_rounds(1'b1, 110);
    test_random_rounds(1'b0, 20);
    test_random_rounds(1'b1, 110);
    test_random_rounds(1'b1, 100);
    test_quiet_finish();
    wait_drained();
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Receiver: long hold-off on request, otherwise short random stall bursts
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      repeat (hold_cycles) @(posedge clk);
      hold_cycles = 0;
      out_stall <= 1'b0;
    end else if (idle_on && rst_n && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_results
    grant_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_grants.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = expected_grants.pop_front();
        check_field("grant_valid", 32'(out_grant_valid), 32'(want.grant_valid));
        check_field("grant_slot", 32'(out_grant_slot), 32'(want.grant_slot));
        check_field("grant_address", out_grant_address, want.grant_address);
        check_field("grant_port", 32'(out_grant_port), 32'(want.grant_port));
        check_field("active_count", 32'(out_active_count), 32'(want.active_count));
        check_field("table_full", 32'(out_table_full), 32'(want.table_full));
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_grants.size());
      $display("testbench: FAIL");
      $finish;
    end
  end

endmodule
